// ===== rtl/clx_pkg.sv =====
// Shared types, codes and lookup functions for the C subset lexer.
package clx_pkg;

  localparam int unsigned DEF_MAX_LEXEME_CHARS = 8;
  localparam int unsigned DEF_LINE_BITS        = 24;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CODE_W   = 4;
  localparam int unsigned TEXT_W   = 64;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LINE_W   = 24;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FILL_W     = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned NUM_KEYWORDS = 9;

  typedef enum logic [CODE_W-1:0] {
    CLS_ID     = 4'd0,
    CLS_KEY    = 4'd1,
    CLS_PUNCT  = 4'd2,
    CLS_REL    = 4'd3,
    CLS_ASSIGN = 4'd4,
    CLS_ARITH  = 4'd5,
    CLS_INT    = 4'd6,
    CLS_CHAR   = 4'd7,
    CLS_ERR    = 4'd8
  } tok_class_e;

  localparam logic [CODE_W-1:0] KIND_NONE = 4'd0;

  // punctuation kinds
  localparam logic [CODE_W-1:0] PU_LPAREN = 4'd0;
  localparam logic [CODE_W-1:0] PU_RPAREN = 4'd1;
  localparam logic [CODE_W-1:0] PU_LBRACE = 4'd2;
  localparam logic [CODE_W-1:0] PU_RBRACE = 4'd3;
  localparam logic [CODE_W-1:0] PU_LBRACK = 4'd4;
  localparam logic [CODE_W-1:0] PU_RBRACK = 4'd5;
  localparam logic [CODE_W-1:0] PU_SEMI   = 4'd6;
  localparam logic [CODE_W-1:0] PU_COMMA  = 4'd7;

  // relational kinds
  localparam logic [CODE_W-1:0] REL_NE = 4'd0;
  localparam logic [CODE_W-1:0] REL_LE = 4'd1;
  localparam logic [CODE_W-1:0] REL_LT = 4'd2;
  localparam logic [CODE_W-1:0] REL_GE = 4'd3;
  localparam logic [CODE_W-1:0] REL_GT = 4'd4;
  localparam logic [CODE_W-1:0] REL_EQ = 4'd5;

  // arithmetic kinds
  localparam logic [CODE_W-1:0] AR_ADD = 4'd0;
  localparam logic [CODE_W-1:0] AR_SUB = 4'd1;
  localparam logic [CODE_W-1:0] AR_DIV = 4'd2;
  localparam logic [CODE_W-1:0] AR_MUL = 4'd3;

  // error kinds
  localparam logic [CODE_W-1:0] ERR_UNKNOWN = 4'd0;
  localparam logic [CODE_W-1:0] ERR_LITERAL = 4'd1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    tok_class_e          token_class;
    logic [CODE_W-1:0]   token_kind;
    logic [TEXT_W-1:0]   lexeme_text;
    logic [LEN_W-1:0]    lexeme_length;
    logic                too_long;
    logic [VALUE_W-1:0]  number_value;
    logic [LINE_W-1:0]   line_number;
    logic                last_of_run;
  } tok_t;

  // tokens produced by one scan step, tok0 first
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } emit_t;

  typedef struct packed {
    logic              room_two;
    logic [FILL_W-1:0] fill;
  } fifo_stat_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] kind;
  } lookup_t;

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic lookup_t punct_lookup(input logic [CHAR_W-1:0] c);
    lookup_t r;
    r.hit = 1'b1;
    case (c)
      CH_LPAREN: r.kind = PU_LPAREN;
      CH_RPAREN: r.kind = PU_RPAREN;
      CH_LBRACE: r.kind = PU_LBRACE;
      CH_RBRACE: r.kind = PU_RBRACE;
      CH_LBRACK: r.kind = PU_LBRACK;
      CH_RBRACK: r.kind = PU_RBRACK;
      CH_SEMI:   r.kind = PU_SEMI;
      CH_COMMA:  r.kind = PU_COMMA;
      default: begin
        r.hit  = 1'b0;
        r.kind = KIND_NONE;
      end
    endcase
    return r;
  endfunction

  // Keyword text packed first character in the low byte, so each string
  // literal is written back to front.
  function automatic logic [TEXT_W-1:0] keyword_text(input int unsigned k);
    logic [TEXT_W-1:0] t;
    case (k)
      0:       t = TEXT_W'("tni");     // int
      1:       t = TEXT_W'("esle");    // else
      2:       t = TEXT_W'("elihw");   // while
      3:       t = TEXT_W'("rahc");    // char
      4:       t = TEXT_W'("diov");    // void
      5:       t = TEXT_W'("nruter");  // return
      6:       t = TEXT_W'("tuoc");    // cout
      7:       t = TEXT_W'("fi");      // if
      8:       t = TEXT_W'("nic");     // cin
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [LEN_W-1:0] keyword_len(input int unsigned k);
    logic [LEN_W-1:0] n;
    case (k)
      0, 8:    n = 8'd3;
      1, 3, 4, 6: n = 8'd4;
      2:       n = 8'd5;
      5:       n = 8'd6;
      7:       n = 8'd2;
      default: n = 8'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/clx_char_if.sv =====
// Character input channel: valid/ready handshake with one source byte.
interface clx_char_if;
  logic                       valid;
  logic                       ready;
  logic [clx_pkg::CHAR_W-1:0] char_code;
  logic                       end_of_input;

  modport source (output valid, char_code, end_of_input, input ready);
  modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

// ===== rtl/clx_token_if.sv =====
// Token output channel: valid/ready handshake with one token.
interface clx_token_if;
  logic                        valid;
  logic                        ready;
  logic [clx_pkg::CODE_W-1:0]  token_class;
  logic [clx_pkg::CODE_W-1:0]  token_kind;
  logic [clx_pkg::TEXT_W-1:0]  lexeme_text;
  logic [clx_pkg::LEN_W-1:0]   lexeme_length;
  logic                        too_long;
  logic [clx_pkg::VALUE_W-1:0] number_value;
  logic [clx_pkg::LINE_W-1:0]  line_number;
  logic                        last_of_run;

  modport source (output valid, token_class, token_kind, lexeme_text, lexeme_length,
                  too_long, number_value, line_number, last_of_run, input ready);
  modport sink   (input valid, token_class, token_kind, lexeme_text, lexeme_length,
                  too_long, number_value, line_number, last_of_run, output ready);
endinterface

// ===== rtl/clx_scan.sv =====
// Scanner state and per-character step logic: up to two tokens per character.
module clx_scan #(
  parameter int unsigned MAX_LEXEME_CHARS = clx_pkg::DEF_MAX_LEXEME_CHARS,
  parameter int unsigned LINE_BITS        = clx_pkg::DEF_LINE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [clx_pkg::CHAR_W-1:0] char_code_i,
  input  logic                       end_of_input_i,
  output clx_pkg::emit_t             emit_o
);
  import clx_pkg::*;

  localparam int unsigned BufW = MAX_LEXEME_CHARS * CHAR_W;
  localparam int unsigned CntW = (LINE_BITS < LINE_W) ? LINE_BITS : LINE_W;
  localparam logic [CntW-1:0] LineMax = '1;
  localparam logic [CntW-1:0] LineOne = CntW'(1);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_LT, M_GT, M_EQ, M_SLASH,
    M_BLOCK, M_STAR, M_LINE, M_QOPEN, M_QCHAR
  } mode_e;

  mode_e               mode_q, mode_d;
  logic [BufW-1:0]     buf_q, buf_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [VALUE_W-1:0]  acc_q, acc_d;
  logic                ovf_q, ovf_d;
  logic [CntW-1:0]     line_q, line_d;
  logic [CHAR_W-1:0]   lit_q, lit_d;

  logic [CHAR_W-1:0]   c;
  logic [BufW-1:0]     buf_add;
  logic [LEN_W-1:0]    len_inc;
  logic [3:0]          digit;
  logic [VALUE_W+3:0]  acc_wide;
  logic [NUM_KEYWORDS-1:0] kw_hit;
  logic [CODE_W-1:0]   kw_idx;
  lookup_t             pu;
  logic [LINE_W-1:0]   line_ext;

  logic                flush, fin, idle, nl_inc;
  tok_class_e          fin_cls;
  logic [CODE_W-1:0]   fin_kind;
  logic [VALUE_W-1:0]  fin_val;
  logic                a_valid, b_valid;
  tok_t                tok_a, tok_b;

  assign c        = char_code_i;
  assign len_inc  = (len_q == '1) ? len_q : len_q + LEN_W'(1);
  assign digit    = 4'(c - CH_ZERO);
  assign acc_wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (VALUE_W + 4)'(digit);
  assign pu       = punct_lookup(c);
  assign line_ext = LINE_W'(line_q);

  // append the character at the current fill position
  always_comb begin
    buf_add = buf_q;
    for (int i = 0; i < int'(MAX_LEXEME_CHARS); i++) begin
      if (len_q == LEN_W'(i)) buf_add[i*CHAR_W +: CHAR_W] = c;
    end
  end

  // keyword compares in parallel; unused buffer bytes are always zero
  always_comb begin
    kw_idx = KIND_NONE;
    for (int k = 0; k < int'(NUM_KEYWORDS); k++) begin
      kw_hit[k] = (len_q == keyword_len(k)) && (TEXT_W'(buf_q) == keyword_text(k));
    end
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (kw_hit[k]) kw_idx = CODE_W'(k);
    end
  end

  always_comb begin
    mode_d   = mode_q;
    buf_d    = buf_q;
    len_d    = len_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    lit_d    = lit_q;
    flush    = 1'b0;
    fin      = 1'b0;
    idle     = 1'b0;
    nl_inc   = 1'b0;
    fin_cls  = CLS_REL;
    fin_kind = KIND_NONE;
    fin_val  = '0;
    b_valid  = 1'b0;
    tok_b    = '0;

    if (end_of_input_i) begin
      flush = 1'b1;
    end else begin
      case (mode_q)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            buf_d = buf_add;
            len_d = len_inc;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            buf_d = buf_add;
            len_d = len_inc;
            if (acc_wide[VALUE_W+3:VALUE_W] != '0) begin
              acc_d = '1;
              ovf_d = 1'b1;
            end else begin
              acc_d = acc_wide[VALUE_W-1:0];
            end
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_LT: begin
          if (c == CH_GT) begin
            fin      = 1'b1;
            fin_kind = REL_NE;
          end else if (c == CH_EQ) begin
            fin      = 1'b1;
            fin_kind = REL_LE;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_GT: begin
          if (c == CH_EQ) begin
            fin      = 1'b1;
            fin_kind = REL_GE;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_EQ: begin
          if (c == CH_EQ) begin
            fin      = 1'b1;
            fin_kind = REL_EQ;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_STAR || c == CH_SLASH) begin
            buf_d  = '0;
            len_d  = '0;
            mode_d = (c == CH_STAR) ? M_BLOCK : M_LINE;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_BLOCK: begin
          if (c == CH_NL) nl_inc = 1'b1;
          else if (c == CH_STAR) mode_d = M_STAR;
        end
        M_STAR: begin
          if (c == CH_SLASH) begin
            mode_d = M_IDLE;
          end else if (c != CH_STAR) begin
            nl_inc = (c == CH_NL);
            mode_d = M_BLOCK;
          end
        end
        M_LINE: begin
          if (c == CH_NL) begin
            nl_inc = 1'b1;
            mode_d = M_IDLE;
          end
        end
        M_QOPEN: begin
          buf_d  = buf_add;
          len_d  = len_inc;
          lit_d  = c;
          nl_inc = (c == CH_NL);
          mode_d = M_QCHAR;
        end
        M_QCHAR: begin
          if (c == CH_QUOTE) begin
            fin     = 1'b1;
            fin_cls = CLS_CHAR;
            fin_val = VALUE_W'(lit_q);
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        default: idle = 1'b1;
      endcase
    end

    // drop the lexeme once it has been emitted
    if (flush || fin || idle) begin
      mode_d = M_IDLE;
      buf_d  = '0;
      len_d  = '0;
      acc_d  = '0;
      ovf_d  = 1'b0;
      lit_d  = '0;
    end

    // scan the character from a clear state
    if (idle) begin
      tok_b.lexeme_text   = TEXT_W'(c);
      tok_b.lexeme_length = LEN_W'(1);
      tok_b.line_number   = line_ext;
      tok_b.last_of_run   = 1'b1;
      if (is_space(c)) begin
        nl_inc = (c == CH_NL);
      end else if (is_alpha(c) || is_digit(c) || c == CH_LT || c == CH_GT ||
                   c == CH_EQ || c == CH_SLASH || c == CH_QUOTE) begin
        buf_d = BufW'(c);
        len_d = LEN_W'(1);
        if (is_alpha(c)) begin
          mode_d = M_IDENT;
        end else if (is_digit(c)) begin
          mode_d = M_INT;
          acc_d  = VALUE_W'(digit);
        end else if (c == CH_LT) begin
          mode_d = M_LT;
        end else if (c == CH_GT) begin
          mode_d = M_GT;
        end else if (c == CH_EQ) begin
          mode_d = M_EQ;
        end else if (c == CH_SLASH) begin
          mode_d = M_SLASH;
        end else begin
          mode_d = M_QOPEN;
        end
      end else begin
        b_valid = 1'b1;
        if (pu.hit) begin
          tok_b.token_class = CLS_PUNCT;
          tok_b.token_kind  = pu.kind;
        end else if (c == CH_PLUS) begin
          tok_b.token_class = CLS_ARITH;
          tok_b.token_kind  = AR_ADD;
        end else if (c == CH_MINUS) begin
          tok_b.token_class = CLS_ARITH;
          tok_b.token_kind  = AR_SUB;
        end else if (c == CH_STAR) begin
          tok_b.token_class = CLS_ARITH;
          tok_b.token_kind  = AR_MUL;
        end else begin
          tok_b.token_class = CLS_ERR;
          tok_b.token_kind  = ERR_UNKNOWN;
        end
      end
    end

    if (end_of_input_i) mode_d = M_IDLE;
  end

  assign line_d = end_of_input_i ? LineOne :
                  (nl_inc && line_q != LineMax) ? line_q + LineOne : line_q;

  // pending token or completed pair / literal, always ahead of tok_b
  always_comb begin
    tok_a               = '0;
    tok_a.line_number   = line_ext;
    a_valid             = 1'b0;
    if (fin) begin
      a_valid             = 1'b1;
      tok_a.token_class   = fin_cls;
      tok_a.token_kind    = fin_kind;
      tok_a.lexeme_text   = TEXT_W'(buf_add);
      tok_a.lexeme_length = len_inc;
      tok_a.too_long      = len_inc > LEN_W'(MAX_LEXEME_CHARS);
      tok_a.number_value  = fin_val;
    end else if (flush) begin
      tok_a.lexeme_text   = TEXT_W'(buf_q);
      tok_a.lexeme_length = len_q;
      tok_a.too_long      = (len_q > LEN_W'(MAX_LEXEME_CHARS)) || ovf_q;
      a_valid             = 1'b1;
      case (mode_q)
        M_IDENT: begin
          tok_a.token_class = (kw_hit != '0) ? CLS_KEY : CLS_ID;
          tok_a.token_kind  = kw_idx;
        end
        M_INT: begin
          tok_a.token_class  = CLS_INT;
          tok_a.number_value = acc_q;
        end
        M_LT: begin
          tok_a.token_class = CLS_REL;
          tok_a.token_kind  = REL_LT;
        end
        M_GT: begin
          tok_a.token_class = CLS_REL;
          tok_a.token_kind  = REL_GT;
        end
        M_EQ: tok_a.token_class = CLS_ASSIGN;
        M_SLASH: begin
          tok_a.token_class = CLS_ARITH;
          tok_a.token_kind  = AR_DIV;
        end
        M_QOPEN, M_QCHAR: begin
          tok_a.token_class = CLS_ERR;
          tok_a.token_kind  = ERR_LITERAL;
        end
        default: a_valid = 1'b0;
      endcase
    end
    tok_a.last_of_run = !b_valid;
  end

  always_comb begin
    emit_o.count = '0;
    emit_o.tok0  = a_valid ? tok_a : tok_b;
    emit_o.tok1  = tok_b;
    if (step_i) emit_o.count = 2'({1'b0, a_valid} + {1'b0, b_valid});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      buf_q  <= '0;
      len_q  <= '0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      line_q <= LineOne;
      lit_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      buf_q  <= buf_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      line_q <= line_d;
      lit_q  <= lit_d;
    end
  end

endmodule

// ===== rtl/clx_fifo.sv =====
// Token queue: takes up to two tokens a cycle, presents one on the output channel.
module clx_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clx_pkg::emit_t       emit_i,
  output clx_pkg::fifo_stat_t  stat_o,
  clx_token_if.source          token_o
);
  import clx_pkg::*;

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);

  tok_t              mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              pop;
  tok_t              head;

  assign pop      = (fill_q != '0) && token_o.ready;
  assign wr_ptr_d = wr_ptr_q + PtrW'(emit_i.count);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign fill_d   = fill_q + FILL_W'(emit_i.count) - FILL_W'(pop);

  assign stat_o.fill     = fill_q;
  assign stat_o.room_two = fill_q <= FILL_W'(FIFO_DEPTH - 2);

  assign head                  = mem_q[rd_ptr_q];
  assign token_o.valid         = fill_q != '0;
  assign token_o.token_class   = head.token_class;
  assign token_o.token_kind    = head.token_kind;
  assign token_o.lexeme_text   = head.lexeme_text;
  assign token_o.lexeme_length = head.lexeme_length;
  assign token_o.too_long      = head.too_long;
  assign token_o.number_value  = head.number_value;
  assign token_o.line_number   = head.line_number;
  assign token_o.last_of_run   = head.last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.count != '0) mem_q[wr_ptr_q] <= emit_i.tok0;
    if (emit_i.count == 2'd2) mem_q[wr_ptr_q + PtrW'(1)] <= emit_i.tok1;
  end

endmodule

// ===== rtl/c_subset_lexer_core.sv =====
// Top level of the C subset lexer: input register, scanner and token queue.
//
// Usage: feed one source byte per transaction on char_i; a transaction with
// end_of_input set carries no byte, flushes the pending token and returns the
// scanner to its start state with the line counter at 1. Tokens leave on
// token_o, one per transaction, in source order; last_of_run marks the final
// token caused by one input transaction.
// Flow: an accepted byte is held in the input register and scanned, one byte
// per cycle, whenever the queue has room for two tokens; otherwise the input
// register waits. A byte that causes two tokens (a pending token closed by a
// punctuation, +, -, * or unknown character) leaves on token_o as two
// transactions; the four-entry token queue absorbs such pairs.
// Stalls: when token_o.ready stays low the queue fills, the scanner holds the
// byte in its input register and char_i.ready drops until space frees up.
// Reset: asynchronous, active low; clears the queue, the input valid flag
// and all scanner state (line counter to 1). No clearing pass is needed.
module c_subset_lexer_core #(
  parameter int unsigned MAX_LEXEME_CHARS = clx_pkg::DEF_MAX_LEXEME_CHARS,
  parameter int unsigned LINE_BITS        = clx_pkg::DEF_LINE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  clx_char_if.sink     char_i,
  clx_token_if.source  token_o
);
  import clx_pkg::*;

  // input register
  logic              in_valid_q;
  logic [CHAR_W-1:0] in_char_q;
  logic              in_eoi_q;

  logic       stage_go;
  emit_t      emit;
  fifo_stat_t fifo_stat;

  // advance the held byte only when the queue can take two tokens
  assign stage_go     = in_valid_q && fifo_stat.room_two;
  assign char_i.ready = !in_valid_q || stage_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  // payload carries no reset
  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_char_q <= char_i.char_code;
      in_eoi_q  <= char_i.end_of_input;
    end
  end

  clx_scan #(
    .MAX_LEXEME_CHARS (MAX_LEXEME_CHARS),
    .LINE_BITS        (LINE_BITS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (stage_go),
    .char_code_i    (in_char_q),
    .end_of_input_i (in_eoi_q),
    .emit_o         (emit)
  );

  clx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .emit_i  (emit),
    .stat_o  (fifo_stat),
    .token_o (token_o)
  );

  // the queue never holds more than its depth
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.fill <= FILL_W'(FIFO_DEPTH))
    else $error("token queue overflow");

  // a byte held back by a full queue stays in the input register
  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !stage_go) |=> (in_valid_q && $stable(in_char_q) && $stable(in_eoi_q)))
    else $error("held input byte lost");

  // line numbers start at one and never wrap to zero
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_o.valid |-> (token_o.line_number != '0))
    else $error("token with line number zero");

  // a step that emits two tokens marks only the second as last of its run
  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.count == 2'd2) |-> (!emit.tok0.last_of_run && emit.tok1.last_of_run))
    else $error("token pair with wrong run marks");

endmodule

// ===== tb/c_subset_lexer_core_tb.sv =====
// Self-checking testbench for c_subset_lexer_core: byte stream in, token stream checked.
`timescale 1ns / 100ps

module c_subset_lexer_core_tb;
  import clx_pkg::*;

  // Scanner build that the block is instantiated with (defaults).
  localparam int unsigned LEXEME_MAX = DEF_MAX_LEXEME_CHARS;
  localparam logic [LINE_W-1:0] LINE_LIMIT =
      (DEF_LINE_BITS >= 24) ? 24'hFF_FFFF : LINE_W'((1 << DEF_LINE_BITS) - 1);
  localparam logic [CODE_W-1:0] KW_NONE = CODE_W'(NUM_KEYWORDS);
  localparam int unsigned MAX_PER_STEP = 2;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  // Scanner modes of the predictor.
  typedef enum logic [3:0] {
    SC_IDLE, SC_IDENT, SC_INT, SC_LT, SC_GT, SC_EQ, SC_SLASH,
    SC_BLOCK, SC_STAR, SC_LINE, SC_QOPEN, SC_QCHAR
  } scan_mode_e;

  logic clk_i;
  logic rst_ni;

  clx_char_if  char_if ();
  clx_token_if tok_if ();

  c_subset_lexer_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .token_o (tok_if)
  );

  // Keyword spellings in kind order, and the operator spellings the stream draws from.
  string kw_words [NUM_KEYWORDS] = '{"int", "else", "while", "char", "void", "return",
                                     "cout", "if", "cin"};
  string op_texts [11] = '{"<>", "<=", "<", ">=", ">", "==", "=", "+", "-", "*", "/"};

  // Predictor state, at its reset values.
  scan_mode_e        lex_mode  = SC_IDLE;
  logic [TEXT_W-1:0] lex_text  = '0;
  logic [LEN_W-1:0]  lex_len   = '0;
  logic [31:0]       lex_value = '0;
  logic              lex_ovf   = 1'b0;
  logic [LINE_W-1:0] lex_line  = LINE_W'(1);
  logic [7:0]        lex_lit   = '0;
  int unsigned       step_tokens;

  // Tokens predicted but not yet seen on token_o, oldest first.
  tok_t predicted_tokens [$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  bit          src_idle = 1'b0;
  bit          sink_idle = 1'b0;
  int unsigned sink_hold_cycles = 0;

  // ------------------------------------------------------------------
  // Clock, timeout
  // ------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("c_subset_lexer_core_tb failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Token predictor
  // ------------------------------------------------------------------
  function automatic logic char_is_letter(input logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
  endfunction

  function automatic logic char_is_num(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE);
  endfunction

  function automatic logic char_is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void lex_newline();
    if (lex_line < LINE_LIMIT) lex_line = lex_line + 1'b1;
  endfunction

  function automatic void lex_clear();
    lex_text  = '0;
    lex_len   = '0;
    lex_value = '0;
    lex_ovf   = 1'b0;
    lex_lit   = '0;
  endfunction

  // Keep only the first LEXEME_MAX bytes, but count all of them (saturating).
  function automatic void lex_append(input logic [7:0] c);
    if (lex_len < LEXEME_MAX) lex_text[8*lex_len +: 8] = c;
    if (lex_len != 8'hFF) lex_len = lex_len + 1'b1;
  endfunction

  function automatic void emit_token(input tok_class_e cls, input logic [CODE_W-1:0] kind,
                                     input logic [31:0] value);
    tok_t t;
    if (step_tokens >= MAX_PER_STEP) return;
    t.token_class   = cls;
    t.token_kind    = kind;
    t.lexeme_text   = lex_text;
    t.lexeme_length = lex_len;
    t.too_long      = (lex_len > LEXEME_MAX) || lex_ovf;
    t.number_value  = value;
    t.line_number   = lex_line;
    t.last_of_run   = 1'b0;
    predicted_tokens = {predicted_tokens, t};
    step_tokens++;
  endfunction

  // Keyword index of the buffered lexeme, KW_NONE when it is a plain identifier.
  function automatic logic [CODE_W-1:0] keyword_match();
    bit same;
    if (lex_len > LEXEME_MAX) return KW_NONE;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (kw_words[k].len() != lex_len) continue;
      same = 1'b1;
      for (int i = 0; i < kw_words[k].len(); i++)
        if (lex_text[8*i +: 8] != kw_words[k][i]) same = 1'b0;
      if (same) return CODE_W'(k);
    end
    return KW_NONE;
  endfunction

  // Close whatever token is pending, then drop back to idle.
  function automatic void lex_flush();
    logic [CODE_W-1:0] kw;
    case (lex_mode)
      SC_IDENT: begin
        kw = keyword_match();
        if (kw != KW_NONE) emit_token(CLS_KEY, kw, '0);
        else emit_token(CLS_ID, KIND_NONE, '0);
      end
      SC_INT:           emit_token(CLS_INT, KIND_NONE, lex_value);
      SC_LT:            emit_token(CLS_REL, REL_LT, '0);
      SC_GT:            emit_token(CLS_REL, REL_GT, '0);
      SC_EQ:            emit_token(CLS_ASSIGN, KIND_NONE, '0);
      SC_SLASH:         emit_token(CLS_ARITH, AR_DIV, '0);
      SC_QOPEN, SC_QCHAR: emit_token(CLS_ERR, ERR_LITERAL, '0);
      default: ;
    endcase
    lex_clear();
    lex_mode = SC_IDLE;
  endfunction

  function automatic void lex_single(input logic [7:0] c, input tok_class_e cls,
                                     input logic [CODE_W-1:0] kind);
    lex_clear();
    lex_append(c);
    emit_token(cls, kind, '0);
    lex_clear();
  endfunction

  function automatic void lex_open(input logic [7:0] c, input scan_mode_e m);
    lex_clear();
    lex_append(c);
    lex_mode = m;
  endfunction

  function automatic void lex_pair(input logic [7:0] c, input logic [CODE_W-1:0] kind);
    lex_append(c);
    emit_token(CLS_REL, kind, '0);
    lex_clear();
    lex_mode = SC_IDLE;
  endfunction

  // Byte seen with nothing pending.
  function automatic void lex_start(input logic [7:0] c);
    if (char_is_blank(c)) begin
      if (c == CH_NL) lex_newline();
    end else if (char_is_letter(c)) begin
      lex_open(c, SC_IDENT);
    end else if (char_is_num(c)) begin
      lex_open(c, SC_INT);
      lex_value = c - CH_ZERO;
    end else begin
      case (c)
        CH_LPAREN: lex_single(c, CLS_PUNCT, PU_LPAREN);
        CH_RPAREN: lex_single(c, CLS_PUNCT, PU_RPAREN);
        CH_LBRACE: lex_single(c, CLS_PUNCT, PU_LBRACE);
        CH_RBRACE: lex_single(c, CLS_PUNCT, PU_RBRACE);
        CH_LBRACK: lex_single(c, CLS_PUNCT, PU_LBRACK);
        CH_RBRACK: lex_single(c, CLS_PUNCT, PU_RBRACK);
        CH_SEMI:   lex_single(c, CLS_PUNCT, PU_SEMI);
        CH_COMMA:  lex_single(c, CLS_PUNCT, PU_COMMA);
        CH_LT:     lex_open(c, SC_LT);
        CH_GT:     lex_open(c, SC_GT);
        CH_EQ:     lex_open(c, SC_EQ);
        CH_SLASH:  lex_open(c, SC_SLASH);
        CH_QUOTE:  lex_open(c, SC_QOPEN);
        CH_PLUS:   lex_single(c, CLS_ARITH, AR_ADD);
        CH_MINUS:  lex_single(c, CLS_ARITH, AR_SUB);
        CH_STAR:   lex_single(c, CLS_ARITH, AR_MUL);
        default:   lex_single(c, CLS_ERR, ERR_UNKNOWN);
      endcase
    end
  endfunction

  // Advance the predictor by one accepted transaction and queue the tokens it causes.
  function automatic void lex_step(input logic [7:0] c, input logic eoi);
    logic [31:0] digit;
    step_tokens = 0;
    if (eoi) begin
      lex_flush();
      lex_line = LINE_W'(1);
    end else begin
      case (lex_mode)
        SC_IDENT: begin
          if (char_is_letter(c) || char_is_num(c)) lex_append(c);
          else begin lex_flush(); lex_start(c); end
        end
        SC_INT: begin
          if (char_is_num(c)) begin
            lex_append(c);
            digit = c - CH_ZERO;
            // saturate rather than wrap
            if (lex_value > (32'hFFFF_FFFF - digit) / 32'd10) begin
              lex_value = 32'hFFFF_FFFF;
              lex_ovf   = 1'b1;
            end else begin
              lex_value = lex_value * 32'd10 + digit;
            end
          end else begin
            lex_flush(); lex_start(c);
          end
        end
        SC_LT: begin
          if (c == CH_GT) lex_pair(c, REL_NE);
          else if (c == CH_EQ) lex_pair(c, REL_LE);
          else begin lex_flush(); lex_start(c); end
        end
        SC_GT: begin
          if (c == CH_EQ) lex_pair(c, REL_GE);
          else begin lex_flush(); lex_start(c); end
        end
        SC_EQ: begin
          if (c == CH_EQ) lex_pair(c, REL_EQ);
          else begin lex_flush(); lex_start(c); end
        end
        SC_SLASH: begin
          if (c == CH_STAR) begin lex_clear(); lex_mode = SC_BLOCK; end
          else if (c == CH_SLASH) begin lex_clear(); lex_mode = SC_LINE; end
          else begin lex_flush(); lex_start(c); end
        end
        SC_BLOCK: begin
          if (c == CH_NL) lex_newline();
          else if (c == CH_STAR) lex_mode = SC_STAR;
        end
        SC_STAR: begin
          // any run of stars followed by a slash closes the comment
          if (c == CH_SLASH) lex_mode = SC_IDLE;
          else if (c != CH_STAR) begin
            if (c == CH_NL) lex_newline();
            lex_mode = SC_BLOCK;
          end
        end
        SC_LINE: begin
          if (c == CH_NL) begin lex_newline(); lex_mode = SC_IDLE; end
        end
        SC_QOPEN: begin
          lex_append(c);
          lex_lit = c;
          if (c == CH_NL) lex_newline();
          lex_mode = SC_QCHAR;
        end
        SC_QCHAR: begin
          if (c == CH_QUOTE) begin
            lex_append(c);
            emit_token(CLS_CHAR, KIND_NONE, {24'd0, lex_lit});
            lex_clear();
            lex_mode = SC_IDLE;
          end else begin
            // bad literal: report what came so far, then rescan this byte
            lex_flush(); lex_start(c);
          end
        end
        default: begin
          lex_mode = SC_IDLE;
          lex_start(c);
        end
      endcase
    end
    if (step_tokens > 0)
      predicted_tokens[predicted_tokens.size()-1].last_of_run = 1'b1;
  endfunction

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------
  function automatic string token_str(input tok_t t);
    return $sformatf("cls %0d kind %0d text %h len %0d long %b val %0d line %0d last %b",
                     t.token_class, t.token_kind, t.lexeme_text, t.lexeme_length,
                     t.too_long, t.number_value, t.line_number, t.last_of_run);
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MISMATCHES) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  function automatic void check_token(input tok_t want, input tok_t got);
    string bad;
    bad = "";
    if (got.token_class   !== want.token_class)   bad = {bad, " class"};
    if (got.token_kind    !== want.token_kind)    bad = {bad, " kind"};
    if (got.lexeme_text   !== want.lexeme_text)   bad = {bad, " text"};
    if (got.lexeme_length !== want.lexeme_length) bad = {bad, " length"};
    if (got.too_long      !== want.too_long)      bad = {bad, " too_long"};
    if (got.number_value  !== want.number_value)  bad = {bad, " value"};
    if (got.line_number   !== want.line_number)   bad = {bad, " line"};
    if (got.last_of_run   !== want.last_of_run)   bad = {bad, " last"};
    if (bad != "")
      report_mismatch({"token field mismatch:", bad, "\n  expected ", token_str(want),
                       "\n  actual   ", token_str(got)});
  endfunction

  // Sample both channels at each rising edge. Check the oldest prediction against each
  // token transaction first, then predict from the byte transaction of the same edge;
  // a byte's tokens never leave in the cycle it is taken, so the order cannot matter.
  always @(posedge clk_i) begin : channel_monitor
    tok_t got;
    if (rst_ni === 1'b1) begin
      if (tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
        got.token_class   = tok_class_e'(tok_if.token_class);
        got.token_kind    = tok_if.token_kind;
        got.lexeme_text   = tok_if.lexeme_text;
        got.lexeme_length = tok_if.lexeme_length;
        got.too_long      = tok_if.too_long;
        got.number_value  = tok_if.number_value;
        got.line_number   = tok_if.line_number;
        got.last_of_run   = tok_if.last_of_run;
        if (predicted_tokens.size() == 0)
          report_mismatch({"token with nothing predicted: ", token_str(got)});
        else
          check_token(predicted_tokens.pop_front(), got);
      end
      if (char_if.valid === 1'b1 && char_if.ready === 1'b1)
        lex_step(char_if.char_code, char_if.end_of_input);
    end
  end

  // ------------------------------------------------------------------
  // Token receiver: random stall bursts, plus a long hold when a test asks for one.
  // ------------------------------------------------------------------
  initial begin : token_receiver
    int unsigned span;
    tok_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_hold_cycles != 0) begin
        span = sink_hold_cycles;
        sink_hold_cycles = 0;
        tok_if.ready <= 1'b0;
        repeat (span) @(posedge clk_i);
        tok_if.ready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 9) == 0) begin
        span = $urandom_range(1, 14);
        tok_if.ready <= 1'b0;
        repeat (span) @(posedge clk_i);
        tok_if.ready <= 1'b1;
      end else begin
        tok_if.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Byte sender
  // ------------------------------------------------------------------
  // Offer one transaction and hold it until taken. Valid stays high on return so that
  // back-to-back transactions need no second assignment in the same step.
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    if (src_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_if.valid        <= 1'b1;
    char_if.char_code    <= c;
    char_if.end_of_input <= eoi;
    @(posedge clk_i);
    while (char_if.ready !== 1'b1) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // End of input carries no byte; drive a random one to show it is ignored.
  task automatic send_eoi();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Drop valid and wait for every predicted token, plus the scan latency.
  task automatic pause_until_drained();
    char_if.valid <= 1'b0;
    @(posedge clk_i);
    while (predicted_tokens.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] r;
    r = 8'($urandom_range(0, 51));
    return (r < 26) ? CH_LC_A + r : CH_UC_A + (r - 8'd26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Send one lexeme (or a bit of noise) of random shape and content.
  task automatic send_random_lexeme();
    int unsigned pick;
    int unsigned count;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      // identifier, keyword, or a long identifier
      if ($urandom_range(0, 5) == 0) begin
        send_text(kw_words[$urandom_range(0, NUM_KEYWORDS - 1)]);
      end else begin
        count = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 5);
        send_item(rand_letter(), 1'b0);
        repeat (count) send_item($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter(),
                                 1'b0);
      end
    end else if (pick < 30) begin
      // integer, sometimes long enough to saturate
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
      repeat (count) send_item(rand_digit(), 1'b0);
    end else if (pick < 40) begin
      case ($urandom_range(0, 7))
        0: send_item(CH_LPAREN, 1'b0);
        1: send_item(CH_RPAREN, 1'b0);
        2: send_item(CH_LBRACE, 1'b0);
        3: send_item(CH_RBRACE, 1'b0);
        4: send_item(CH_LBRACK, 1'b0);
        5: send_item(CH_RBRACK, 1'b0);
        6: send_item(CH_SEMI, 1'b0);
        default: send_item(CH_COMMA, 1'b0);
      endcase
    end else if (pick < 52) begin
      send_text(op_texts[$urandom_range(0, 10)]);
    end else if (pick < 60) begin
      // well-formed literal around any byte, quote and newline included
      send_item(CH_QUOTE, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b0);
      send_item(CH_QUOTE, 1'b0);
    end else if (pick < 64) begin
      // broken literal: the closing byte is not a quote
      send_item(CH_QUOTE, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b0);
      do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
      send_item(b, 1'b0);
    end else if (pick < 71) begin
      send_text("/*");
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 4))
          0: send_item(CH_STAR, 1'b0);
          1: send_item(CH_NL, 1'b0);
          2: send_item(CH_SLASH, 1'b0);
          3: send_item(rand_letter(), 1'b0);
          default: send_item(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end
      repeat ($urandom_range(1, 3)) send_item(CH_STAR, 1'b0);
      send_item(CH_SLASH, 1'b0);
    end else if (pick < 76) begin
      send_text("//");
      repeat ($urandom_range(0, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
      send_item(CH_NL, 1'b0);
    end else if (pick < 88) begin
      if ($urandom_range(0, 2) == 0) send_item(CH_SPACE, 1'b0);
      else send_item(8'($urandom_range(CH_TAB, CH_CR)), 1'b0);
    end else if (pick < 94) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 97) begin
      // bytes that no token class takes; each becomes an unknown-character error token
      if ($urandom_range(0, 1) == 0) send_item(8'($urandom_range(128, 255)), 1'b0);
      else send_item(8'($urandom_range(0, CH_TAB - 1)), 1'b0);
    end else begin
      send_eoi();
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Extreme bytes, every relational and arithmetic operator, assignment, a literal
  // holding a quote, a multi-star comment close across a newline, and end of input
  // over an open literal.
  task automatic test_directed();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("'''");
    send_text("<><=<;>=>;==/=*+-");
    send_text("/**\n**/");
    send_item(CH_QUOTE, 1'b0);
    send_eoi();
  endtask

  // One identifier past the length counter's saturation point.
  task automatic test_long_lexeme();
    repeat (260) send_item(rand_letter(), 1'b0);
    send_item(CH_SEMI, 1'b0);
  endtask

  // Random stream; switch idling on either side on and off in stretches.
  task automatic test_random_stream(input int unsigned stop_at);
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 39) == 0) begin
        src_idle  = ($urandom_range(0, 2) != 0);
        sink_idle = ($urandom_range(0, 2) != 0);
      end
      send_random_lexeme();
    end
  endtask

  // Sender runs a short burst, then stops until every token is out.
  task automatic test_sender_pause();
    int unsigned stop_at;
    stop_at = items_sent + 40;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    while (items_sent < stop_at) send_random_lexeme();
    pause_until_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering bytes that
  // close one token and emit another, so the token queue fills and input stalls.
  task automatic test_sink_hold();
    src_idle = 1'b0;
    sink_hold_cycles = 80;
    repeat (30) begin
      send_item(rand_letter(), 1'b0);
      send_item(CH_SEMI, 1'b0);
    end
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_steady_stream(input int unsigned stop_at);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    while (items_sent < stop_at) send_random_lexeme();
    send_eoi();
  endtask

  initial begin : stimulus
    int unsigned drain_cycles;
    rst_ni               <= 1'b0;
    char_if.valid        <= 1'b0;
    char_if.char_code    <= '0;
    char_if.end_of_input <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_long_lexeme();
    test_random_stream(900);
    test_sender_pause();
    test_sink_hold();
    test_random_stream(1050);
    test_steady_stream(1450);

    // Drain: wait for the last predicted token, with a limit, then watch on for anything unexpected.
    char_if.valid <= 1'b0;
    drain_cycles = 0;
    @(posedge clk_i);
    while (predicted_tokens.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (predicted_tokens.size() != 0)
      report_mismatch($sformatf("%0d predicted tokens never arrived",
                                predicted_tokens.size()));

    if (mismatch_count == 0) begin
      $display("c_subset_lexer_core_tb passed");
    end else begin
      $display("c_subset_lexer_core_tb failed");
    end
    $finish;
  end

endmodule
